>>> rtl/spma_pkg.sv
// ----------------------------------------------------------------------------
// Sparse polynomial merge-add package
// Shared types, opcodes and command/status structs for controller and datapath.
// ----------------------------------------------------------------------------
package spma_pkg;

    localparam int MAX_TERMS_DEF = 32;
    localparam int EXP_W  = 16;
    localparam int COEF_W = 32;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_RUN    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_a;     // append the input term to store A
        logic load_b;     // append the input term to store B
        logic clear;      // empty both stores
        logic sort_init;  // start the insertion sort of the selected store
        logic sort_sel;   // 0 sorts A, 1 sorts B
        logic sort_step;  // one compare/shift step of the sort
        logic merge_init; // reset merge pointers and the held-term flag
        logic merge_rd;   // register the current heads of both stores
        logic merge_step; // produce the output for the registered heads
        logic out_take;   // the output register was taken downstream
    } spma_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic sort_done;
        logic merge_done; // both pointers have reached their counts
        logic out_full;   // the output register holds an untaken result
    } spma_sts_t;

endpackage

>>> rtl/spma_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse polynomial merge-add controller
// Sequences load, clear, sort and merge commands for the datapath.
// ----------------------------------------------------------------------------
module spma_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_op,
    input  logic                 m_ready,
    input  logic                 m_valid,
    output spma_pkg::spma_cmd_t  cmd,
    input  spma_pkg::spma_sts_t  sts
);
    import spma_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SORTA  = 6'b000010,
        ST_SORTB  = 6'b000100,
        ST_MREAD  = 6'b001000,
        ST_MSTEP  = 6'b010000,
        ST_FINAL  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    logic   sel_reg, sel_next;

    assign s_ready = (state_reg == ST_IDLE) && !sts.out_full;
    assign accept  = s_valid && s_ready;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.out_take = m_valid && m_ready;
        cmd.sort_sel = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (op_t'(s_op))
                        OP_LOAD_A: cmd.load_a = 1'b1;
                        OP_LOAD_B: cmd.load_b = 1'b1;
                        OP_CLEAR:  cmd.clear  = 1'b1;
                        OP_RUN: begin
                            cmd.sort_init = 1'b1;
                            cmd.sort_sel  = 1'b0;
                            sel_next      = 1'b0;
                            state_next    = ST_SORTA;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SORTA: begin
                if (sts.sort_done) begin
                    cmd.sort_init = 1'b1;
                    cmd.sort_sel  = 1'b1;
                    sel_next      = 1'b1;
                    state_next    = ST_SORTB;
                end else begin
                    cmd.sort_step = 1'b1;
                end
            end
            ST_SORTB: begin
                if (sts.sort_done) begin
                    cmd.merge_init = 1'b1;
                    state_next     = ST_MREAD;
                end else begin
                    cmd.sort_step = 1'b1;
                end
            end
            ST_MREAD: begin
                if (sts.merge_done) begin
                    state_next = ST_FINAL;
                end else begin
                    cmd.merge_rd = 1'b1;
                    state_next   = ST_MSTEP;
                end
            end
            ST_MSTEP: begin
                // Wait for room in the output register before emitting.
                if (!sts.out_full || cmd.out_take) begin
                    cmd.merge_step = 1'b1;
                    state_next     = ST_MREAD;
                end
            end
            ST_FINAL: begin
                // The datapath flushes its held term or the empty marker.
                if (!sts.out_full || cmd.out_take) begin
                    cmd.merge_step = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // A new transaction is never taken while a run is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input accepted during a run");
    // A run always starts by sorting store A.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_RUN) |=> (state_reg == ST_SORTA))
        else $error("run did not start the sort");
    // The merge only emits while it can place a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.merge_step |-> (!sts.out_full || cmd.out_take))
        else $error("merge step with a full output register");

endmodule

>>> rtl/spma_dp.sv
// ----------------------------------------------------------------------------
// Sparse polynomial merge-add datapath
// Term stores, insertion-sort engine, merge pointers, adder and output register.
// ----------------------------------------------------------------------------
module spma_dp #(
    parameter int MAX_TERMS = spma_pkg::MAX_TERMS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic signed [15:0]          s_exponent,
    input  logic signed [31:0]          s_coefficient,
    input  spma_pkg::spma_cmd_t         cmd,
    output spma_pkg::spma_sts_t         sts,
    output logic                        m_valid,
    output logic signed [15:0]          m_out_exponent,
    output logic signed [31:0]          m_out_coefficient,
    output logic                        m_term_valid,
    output logic                        m_last,
    output logic                        m_saturated,
    output logic                        m_dropped
);
    import spma_pkg::*;

    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int TW = EXP_W + COEF_W;

    // Each term is {exponent, coefficient}.
    logic [TW-1:0] mem_a [MAX_TERMS];
    logic [TW-1:0] mem_b [MAX_TERMS];

    logic [CW-1:0] cnt_a_reg, cnt_b_reg;
    logic          drop_reg;

    // Sort engine: insertion sort.
    // phase 0 reads s[j-1]; phase 1 captures the read, then compares and writes.
    logic [CW-1:0] si_reg;       // outer index i
    logic [CW-1:0] sj_reg;       // inner index j
    logic [TW-1:0] skey_reg;     // term being inserted
    logic          sph_reg;      // 0: need key fetch/read, 1: compare
    logic          sload_reg;    // key is being fetched
    logic [TW-1:0] srd_reg;      // registered read of s[j-1]
    logic          sdone_reg;
    logic          key_wait_reg;

    logic [CW-1:0] sn;
    assign sn = cmd.sort_sel ? cnt_b_reg : cnt_a_reg;

    // Merge state.
    logic [CW-1:0] mi_reg, mj_reg;
    logic [TW-1:0] ha_reg, hb_reg;

    // Output register, holding one term.
    logic          ov_reg;
    logic [EXP_W-1:0]  oe_reg;
    logic [COEF_W-1:0] oc_reg;
    logic          otv_reg, olast_reg, osat_reg, odrop_reg;

    // A term is held back one step so the final one can carry last.
    logic              hv_reg;
    logic [EXP_W-1:0]  he_reg;
    logic [COEF_W-1:0] hc_reg;
    logic              hs_reg;

    logic [IW-1:0] wr_idx, rd_idx;
    logic          wr_en_a, wr_en_b;
    logic [TW-1:0] wr_data;

    // Store write port shared by loads and the sort.
    always_comb begin
        wr_en_a = 1'b0;
        wr_en_b = 1'b0;
        wr_idx  = '0;
        wr_data = {s_exponent, s_coefficient};
        if (cmd.load_a && s_coefficient != '0 && cnt_a_reg < CW'(MAX_TERMS)) begin
            wr_en_a = 1'b1;
            wr_idx  = cnt_a_reg[IW-1:0];
        end else if (cmd.load_b && s_coefficient != '0 &&
                     cnt_b_reg < CW'(MAX_TERMS)) begin
            wr_en_b = 1'b1;
            wr_idx  = cnt_b_reg[IW-1:0];
        end else if (cmd.sort_step && sph_reg && !sload_reg && key_wait_reg) begin
            // Shift s[j-1] up, or drop the key into place.
            if ($signed(srd_reg[TW-1 -: EXP_W]) > $signed(skey_reg[TW-1 -: EXP_W])
                && sj_reg != '0) begin
                wr_data = srd_reg;
            end else begin
                wr_data = skey_reg;
            end
            wr_idx  = sj_reg[IW-1:0];
            wr_en_a = !cmd.sort_sel;
            wr_en_b = cmd.sort_sel;
        end
    end

    // Read address for the sort engine.
    always_comb begin
        if (sload_reg) rd_idx = si_reg[IW-1:0];
        else           rd_idx = IW'(sj_reg - CW'(1));
    end

    logic [TW-1:0] rda_reg, rdb_reg;
    logic [TW-1:0] ma_reg, mb_reg;

    always_ff @(posedge aclk) begin
        if (wr_en_a) mem_a[wr_idx] <= wr_data;
        if (wr_en_b) mem_b[wr_idx] <= wr_data;
        rda_reg <= mem_a[rd_idx];
        rdb_reg <= mem_b[rd_idx];
        if (cmd.merge_rd) begin
            ma_reg <= mem_a[mi_reg[IW-1:0]];
            mb_reg <= mem_b[mj_reg[IW-1:0]];
        end
    end

    logic [TW-1:0] srd;
    assign srd = cmd.sort_sel ? rdb_reg : rda_reg;

    // Counts and sticky drop flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            if (cmd.clear) begin
                cnt_a_reg <= '0;
                cnt_b_reg <= '0;
            end
            if (cmd.load_a && s_coefficient != '0) begin
                if (cnt_a_reg < CW'(MAX_TERMS)) cnt_a_reg <= cnt_a_reg + CW'(1);
                else                            drop_reg  <= 1'b1;
            end
            if (cmd.load_b && s_coefficient != '0) begin
                if (cnt_b_reg < CW'(MAX_TERMS)) cnt_b_reg <= cnt_b_reg + CW'(1);
                else                            drop_reg  <= 1'b1;
            end
        end
    end

    // Sort sequencer. States: key fetch (sload), read wait (sph 0), compare (sph 1).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            si_reg       <= '0;
            sj_reg       <= '0;
            sph_reg      <= 1'b0;
            sload_reg    <= 1'b0;
            sdone_reg    <= 1'b0;
            key_wait_reg <= 1'b0;
            skey_reg     <= '0;
            srd_reg      <= '0;
        end else if (cmd.sort_init) begin
            si_reg       <= CW'(1);
            sj_reg       <= CW'(1);
            sph_reg      <= 1'b0;
            sload_reg    <= 1'b1;
            key_wait_reg <= 1'b0;
            sdone_reg    <= (sn <= CW'(1));
        end else if (cmd.sort_step && !sdone_reg) begin
            if (sload_reg) begin
                // Address of s[i] was presented; next cycle its data arrives.
                if (!key_wait_reg) begin
                    key_wait_reg <= 1'b1;
                end else begin
                    skey_reg     <= srd;
                    key_wait_reg <= 1'b0;
                    sload_reg    <= 1'b0;
                    sj_reg       <= si_reg;
                    sph_reg      <= 1'b0;
                end
            end else if (!sph_reg) begin
                // s[j-1] is being read.
                sph_reg <= 1'b1;
            end else if (!key_wait_reg) begin
                srd_reg      <= srd;
                key_wait_reg <= 1'b1;
                sph_reg      <= 1'b1;
            end else begin
                key_wait_reg <= 1'b0;
                if (sj_reg != '0 &&
                    $signed(srd_reg[TW-1 -: EXP_W]) > $signed(skey_reg[TW-1 -: EXP_W])) begin
                    sj_reg  <= sj_reg - CW'(1);
                    sph_reg <= 1'b0;
                    if (sj_reg == CW'(1)) begin
                        // Next position is zero: no read needed, compare fails.
                        sph_reg <= 1'b1;
                        key_wait_reg <= 1'b1;
                    end
                end else begin
                    si_reg    <= si_reg + CW'(1);
                    sload_reg <= 1'b1;
                    if (si_reg + CW'(1) >= sn) sdone_reg <= 1'b1;
                end
            end
        end
    end

    // The compare-and-write in the combinational port must happen only on
    // the deciding cycle; gate it with key_wait_reg.
    assign sts.sort_done = sdone_reg;

    // Merge: choose from the registered heads.
    logic a_left, b_left;
    logic signed [EXP_W-1:0]  ea, eb;
    logic signed [COEF_W-1:0] ca, cb;
    logic signed [COEF_W:0]   sum;
    assign a_left = mi_reg < cnt_a_reg;
    assign b_left = mj_reg < cnt_b_reg;
    assign ea  = ma_reg[TW-1 -: EXP_W];
    assign eb  = mb_reg[TW-1 -: EXP_W];
    assign ca  = ma_reg[COEF_W-1:0];
    assign cb  = mb_reg[COEF_W-1:0];
    assign sum = {ca[COEF_W-1], ca} + {cb[COEF_W-1], cb};
    assign sts.merge_done = !a_left && !b_left;

    logic              pick_v, pick_s, take_a, take_b;
    logic [EXP_W-1:0]  pick_e;
    logic [COEF_W-1:0] pick_c;

    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        pick_v = 1'b1;
        pick_s = 1'b0;
        pick_e = ea;
        pick_c = ca;
        if (!a_left || (b_left && eb < ea)) begin
            take_b = 1'b1;
            pick_e = eb;
            pick_c = cb;
        end else if (!b_left || ea < eb) begin
            take_a = 1'b1;
        end else begin
            take_a = 1'b1;
            take_b = 1'b1;
            if (sum[COEF_W] != sum[COEF_W-1]) begin
                pick_s = 1'b1;
                pick_c = sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}}
                                     : {1'b0, {(COEF_W-1){1'b1}}};
            end else begin
                pick_c = sum[COEF_W-1:0];
            end
            pick_v = (pick_c != '0);
        end
    end

    logic step_emit, final_step, out_load;
    assign final_step = cmd.merge_step && sts.merge_done;
    assign step_emit  = cmd.merge_step && !sts.merge_done;
    assign out_load   = (step_emit && pick_v && hv_reg) || final_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mi_reg      <= '0;
            mj_reg      <= '0;
            hv_reg      <= 1'b0;
            ov_reg      <= 1'b0;
        end else begin
            // The output register fills on a release and empties when taken.
            if (out_load)          ov_reg <= 1'b1;
            else if (cmd.out_take) ov_reg <= 1'b0;
            if (cmd.merge_init) begin
                mi_reg      <= '0;
                mj_reg      <= '0;
                hv_reg      <= 1'b0;
            end
            if (step_emit) begin
                if (take_a) mi_reg <= mi_reg + CW'(1);
                if (take_b) mj_reg <= mj_reg + CW'(1);
                if (pick_v) begin
                    hv_reg <= 1'b1;
                    he_reg <= pick_e;
                    hc_reg <= pick_c;
                    hs_reg <= pick_s;
                    // Release the previously held term, not last.
                    if (hv_reg) begin
                        oe_reg    <= he_reg;
                        oc_reg    <= hc_reg;
                        osat_reg  <= hs_reg;
                        otv_reg   <= 1'b1;
                        olast_reg <= 1'b0;
                        odrop_reg <= drop_reg;
                    end
                end
            end
            if (final_step) begin
                hv_reg    <= 1'b0;
                olast_reg <= 1'b1;
                odrop_reg <= drop_reg;
                otv_reg   <= hv_reg;
                oe_reg    <= hv_reg ? he_reg : '0;
                oc_reg    <= hv_reg ? hc_reg : '0;
                osat_reg  <= hv_reg ? hs_reg : 1'b0;
            end
        end
    end

    assign sts.out_full      = ov_reg;
    assign m_valid           = ov_reg;
    assign m_out_exponent    = oe_reg;
    assign m_out_coefficient = oc_reg;
    assign m_term_valid      = otv_reg;
    assign m_last            = olast_reg;
    assign m_saturated       = osat_reg;
    assign m_dropped         = odrop_reg;

    // Merge pointers never pass their counts while the merge runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.merge_rd || cmd.merge_step) |->
            ((mi_reg <= cnt_a_reg) && (mj_reg <= cnt_b_reg)))
        else $error("merge pointer overran its store");
    // Once set, the drop flag stays set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        drop_reg |=> drop_reg)
        else $error("drop flag cleared");
    // An empty marker is always the last item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !otv_reg) |-> olast_reg)
        else $error("empty result not marked last");

endmodule

>>> rtl/sparse_polynomial_merge_add.sv
// A run sorts both stores with a shared insertion-sort engine and then merges them,
// one head or a matching pair of heads per step, and finally flushes the held last
// item. Throughput: one load or clear every cycle while the block is idle and its
// output register is empty.
// Reset: synchronous active-low aresetn empties both stores and clears the drop flag.
// ----------------------------------------------------------------------------
// Sparse polynomial merge-add top level
// Loads terms into two stores, then sorts and merges them with saturating adds.
// ----------------------------------------------------------------------------
module sparse_polynomial_merge_add #(
    parameter int MAX_TERMS = spma_pkg::MAX_TERMS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_op,
    input  logic signed [15:0]   s_exponent,
    input  logic signed [31:0]   s_coefficient,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_out_exponent,
    output logic signed [31:0]   m_out_coefficient,
    output logic                 m_term_valid,
    output logic                 m_last,
    output logic                 m_saturated,
    output logic                 m_dropped
);
    import spma_pkg::*;

    spma_cmd_t cmd;
    spma_sts_t sts;

    spma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .cmd     (cmd),
        .sts     (sts)
    );

    spma_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_exponent        (s_exponent),
        .s_coefficient     (s_coefficient),
        .cmd               (cmd),
        .sts               (sts),
        .m_valid           (m_valid),
        .m_out_exponent    (m_out_exponent),
        .m_out_coefficient (m_out_coefficient),
        .m_term_valid      (m_term_valid),
        .m_last            (m_last),
        .m_saturated       (m_saturated),
        .m_dropped         (m_dropped)
    );

endmodule
